/* rtl/lst_pkg.sv */
// Shared types and constants for the lock statistics table.
// Used by lst_front, lst_back and lock_statistics_table; no dependencies.
package lst_pkg;

  localparam int BUCKETS          = 1024;
  localparam int SLOTS_PER_BUCKET = 32;
  localparam int HASH_SHIFT       = 5;
  localparam int BUCKET_W         = $clog2(BUCKETS);
  localparam int SLOT_W           = $clog2(SLOTS_PER_BUCKET);
  localparam int SLOT_TOTAL       = BUCKETS * SLOTS_PER_BUCKET;
  localparam int IDX_W            = $clog2(SLOT_TOTAL);

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 184;

  // event kinds
  localparam logic [1:0] KIND_LOCK   = 2'd0;
  localparam logic [1:0] KIND_TRY    = 2'd1;
  localparam logic [1:0] KIND_UNLOCK = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_EXIST = 2'd0;
  localparam logic [1:0] STAT_NEW   = 2'd1;
  localparam logic [1:0] STAT_OVF   = 2'd2;
  localparam logic [1:0] STAT_CLR   = 2'd3;

  typedef struct packed {
    logic [1:0]          kind;
    logic [31:0]         lock_address;
    logic [31:0]         caller_word;
    logic                got_first_try;
    logic                interrupts_masked;
    logic                has_thread;
    logic [31:0]         thread_depth;
    logic [31:0]         timestamp;
    logic [BUCKET_W-1:0] bucket;
    logic                is_clear;
  } qitem_t;

  typedef struct packed {
    logic [31:0] success_count;
    logic [31:0] fail_count;
    logic [31:0] masked_count;
    logic [31:0] depth_value;
    logic [31:0] time_value;
  } stats_t;

  typedef enum logic [1:0] {
    ST_CLR,
    ST_IDLE,
    ST_PROBE,
    ST_CLR_OUT
  } lst_state_t;

endpackage

/* rtl/lock_statistics_table.sv */
// Lock statistics table, top level.
// An accepted event is queued, popped when the back end is idle, then probes its bucket
// one slot a cycle until it settles on probe k (1..32): a hit, an empty or the last slot.
// The next event is probed only once the previous result is registered.
// A clear event emits its result, then sweeps all 32768 entries, one entry a cycle.
// Reset (rst_n low, synchronous) starts the same sweep; events queue but wait until done.
module lock_statistics_table
  import lst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [31:0] lock_address, [63:32] caller_word, [64] got_first_try,
  // [65] interrupts_masked, [66] has_thread, [98:67] thread_depth,
  // [130:99] timestamp, rest zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [9:0] bucket, [15:10] slot, [16] acquired, [48:17] success_count,
  // [80:49] fail_count, [112:81] masked_count, [144:113] depth_value,
  // [176:145] time_value, rest zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [1:0]            out_tuser
);

  logic   q_valid;
  logic   q_pop;
  qitem_t q_item;

  lst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  lst_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* rtl/lst_front.sv */
// Front end: accepts events, derives the bucket, queues them (two deep).
// Depends on lst_pkg.
module lst_front
  import lst_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [1:0]           in_tuser,
  output logic                 q_valid,
  output qitem_t               q_item,
  input  logic                 q_pop
);

  qitem_t     fifo_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  qitem_t     cls;
  logic       push;

  // classify incoming item
  always_comb begin
    cls.kind              = in_tuser;
    cls.lock_address      = in_tdata[31:0];
    cls.caller_word       = in_tdata[63:32];
    cls.got_first_try     = in_tdata[64];
    cls.interrupts_masked = in_tdata[65];
    cls.has_thread        = in_tdata[66];
    cls.thread_depth      = in_tdata[98:67];
    cls.timestamp         = in_tdata[130:99];
    cls.bucket            = in_tdata[HASH_SHIFT +: BUCKET_W];
    cls.is_clear          = (in_tuser == KIND_CLEAR);
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = fifo_r[rd_ptr_r];

  // queue pointers
  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

endmodule

/* rtl/lst_back.sv */
// Back end: bucket probe, counter update, table clear sweep, result register.
// Depends on lst_pkg; holds the tag, caller and statistics memories.
module lst_back
  import lst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  qitem_t                q_item,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser
);

  logic [32:0] tag_mem    [SLOT_TOTAL];
  logic [31:0] caller_mem [SLOT_TOTAL];
  stats_t      stat_mem   [SLOT_TOTAL];

  lst_state_t        state_r, state_nxt;
  qitem_t            item_r;
  logic [SLOT_W-1:0] chk_r;
  logic              pend_r;
  logic [IDX_W-1:0]  clr_cnt_r;
  stats_t            ovf_r;
  logic [32:0]       tag_q_r;
  stats_t            stat_q_r;

  logic              out_valid_r;
  logic [1:0]        o_status_r;
  logic [9:0]        o_bucket_r;
  logic [5:0]        o_slot_r;
  logic              o_acq_r;
  stats_t            o_stats_r;

  logic              out_free;
  logic              hit, empty, last_slot, done, decide;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_a;
  logic [SLOT_W-1:0] iss_slot;
  logic              clr_last;
  stats_t            old_s, new_s;
  logic              acq;
  logic [IDX_W-1:0]  cur_idx;

  assign out_free  = !out_valid_r || out_tready;
  assign hit       = tag_q_r[32] && (tag_q_r[31:0] == item_r.lock_address);
  assign empty     = !tag_q_r[32];
  assign last_slot = (chk_r == SLOT_W'(SLOTS_PER_BUCKET - 1));
  assign done      = pend_r && (hit || empty || last_slot);
  assign decide    = (state_r == ST_PROBE) && done && out_free;
  assign clr_last  = (clr_cnt_r == IDX_W'(SLOT_TOTAL - 1));
  assign cur_idx   = {item_r.bucket, chk_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:     if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:    if (q_valid) state_nxt = q_item.is_clear ? ST_CLR_OUT : ST_PROBE;
      ST_PROBE:   if (decide) state_nxt = ST_IDLE;
      ST_CLR_OUT: if (out_free) state_nxt = ST_CLR;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop    = (state_r == ST_IDLE) && q_valid;
    iss_slot = pend_r ? chk_r + SLOT_W'(1) : '0;
    rd_en    = (state_r == ST_PROBE) && !done;
    rd_a     = {item_r.bucket, iss_slot};
  end

  // counter update for the chosen entry
  always_comb begin
    old_s = (hit || empty) ? stat_q_r : ovf_r;
    new_s = old_s;
    acq   = 1'b1;
    unique case (item_r.kind)
      KIND_LOCK: begin
        if (item_r.has_thread) new_s.depth_value = item_r.thread_depth;
        if (item_r.interrupts_masked) new_s.masked_count = old_s.masked_count + 32'd1;
        if (item_r.got_first_try) new_s.success_count = old_s.success_count + 32'd1;
        else new_s.fail_count = old_s.fail_count + 32'd1;
        new_s.time_value = item_r.timestamp - old_s.time_value;
      end
      KIND_TRY: begin
        if (item_r.interrupts_masked) new_s.masked_count = old_s.masked_count + 32'd1;
        if (item_r.got_first_try) begin
          new_s.success_count = old_s.success_count + 32'd1;
          new_s.time_value    = item_r.timestamp - old_s.time_value;
          if (item_r.has_thread) new_s.depth_value = item_r.thread_depth;
        end else begin
          new_s.fail_count = old_s.fail_count + 32'd1;
          acq              = 1'b0;
        end
      end
      default: begin
        new_s.time_value = item_r.timestamp - old_s.time_value;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      if (state_r == ST_IDLE) pend_r <= 1'b0;
      else if (rd_en) pend_r <= 1'b1;
      if (decide || ((state_r == ST_CLR_OUT) && out_free)) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) item_r <= q_item;
    if (rd_en) chk_r <= iss_slot;
    if ((state_r == ST_CLR) && (clr_cnt_r == '0)) ovf_r <= '0;
    else if (decide && !(hit || empty)) ovf_r <= new_s;
    if (decide) begin
      o_status_r <= hit ? STAT_EXIST : (empty ? STAT_NEW : STAT_OVF);
      o_bucket_r <= 10'(item_r.bucket);
      o_slot_r   <= (hit || empty) ? 6'(chk_r) : 6'(SLOTS_PER_BUCKET);
      o_acq_r    <= acq;
      o_stats_r  <= new_s;
    end else if ((state_r == ST_CLR_OUT) && out_free) begin
      o_status_r <= STAT_CLR;
      o_bucket_r <= '0;
      o_slot_r   <= '0;
      o_acq_r    <= 1'b1;
      o_stats_r  <= '0;
    end
  end

  // tag and statistics memories
  always_ff @(posedge clk) begin
    if (state_r == ST_CLR) begin
      tag_mem[clr_cnt_r]  <= '0;
      stat_mem[clr_cnt_r] <= '0;
    end else if (decide && (hit || empty)) begin
      stat_mem[cur_idx] <= new_s;
      if (empty) tag_mem[cur_idx] <= {1'b1, item_r.lock_address};
    end
    if (rd_en) begin
      tag_q_r  <= tag_mem[rd_a];
      stat_q_r <= stat_mem[rd_a];
    end
  end

  // caller word per claimed slot
  always_ff @(posedge clk) begin
    if (state_r == ST_CLR) caller_mem[clr_cnt_r] <= '0;
    else if (decide && empty) caller_mem[cur_idx] <= item_r.caller_word;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_status_r;
  assign out_tdata  = {7'd0, o_stats_r.time_value, o_stats_r.depth_value,
                       o_stats_r.masked_count, o_stats_r.fail_count,
                       o_stats_r.success_count, o_acq_r, o_slot_r, o_bucket_r};

endmodule
